[src/fbpm_pkg.sv]
// ----------------------------------------------------------------------------
// fbpm_pkg
// Shared types and constants of the frame buffer pool manager.
// ----------------------------------------------------------------------------
package fbpm_pkg;

  localparam int POOL_ENTRIES_DEF = 8;
  localparam int RING_DEPTH_DEF   = 8;

  localparam logic [32:0] ALIGN_ADD  = 33'd15;
  localparam logic [31:0] ALIGN_MASK = 32'hffff_fff0;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_REQUEST = 3'd1,
    OP_ENQUEUE = 3'd2,
    OP_DEQUEUE = 3'd3,
    OP_QUERY   = 3'd4,
    OP_RELEASE = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    REG_REGION_START  = 3'd0,
    REG_REGION_LENGTH = 3'd1,
    REG_REQUESTED     = 3'd2,
    REG_FRAME_WIDTH   = 3'd3,
    REG_FRAME_HEIGHT  = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_LAYOUT,
    ST_TRIM,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;     // capture opcode and index, size multiply
    logic simple;    // execute a simple opcode, or the first step of create
    logic init;      // set up create
    logic lay_step;  // write one entry
    logic trim_step; // check fit of top buffer
    logic finish;    // close create
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_create;
    logic create_fail; // zero region or zero count
    logic lay_last;
    logic trim_done;
  } stat_t;

endpackage

[src/fbpm_ctrl.sv]
// ----------------------------------------------------------------------------
// fbpm_ctrl
// Command sequencer: simple commands, or the create walk.
// ----------------------------------------------------------------------------
module fbpm_ctrl
  import fbpm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_SIZE;
      ST_SIZE: begin
        if (!stat.is_create || stat.create_fail) state_next = ST_IDLE;
        else state_next = ST_LAYOUT;
      end
      ST_LAYOUT: if (stat.lay_last) state_next = ST_TRIM;
      ST_TRIM:   if (stat.trim_done) state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_SIZE: begin
        cmd.simple = 1'b1;
        cmd.init   = stat.is_create;
      end
      ST_LAYOUT: cmd.lay_step  = 1'b1;
      ST_TRIM:   cmd.trim_step = 1'b1;
      ST_DONE:   cmd.finish    = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> state == ST_SIZE)
    else $error("start not taken");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |=> state == ST_IDLE)
    else $error("create did not close");
  // init rides along with simple in the size step
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.latch, cmd.simple, cmd.lay_step, cmd.trim_step, cmd.finish}))
    else $error("commands overlap");

endmodule

[src/fbpm_datapath.sv]
// ----------------------------------------------------------------------------
// fbpm_datapath
// Pool entries, ring queue and result registers.
// ----------------------------------------------------------------------------
module fbpm_datapath
  import fbpm_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int RING_DEPTH   = RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [2:0]  opcode,
  input  logic [7:0]  buffer_index,
  input  logic [31:0] region_start,
  input  logic [31:0] region_length,
  input  logic [7:0]  requested_buffers,
  input  logic [15:0] frame_width,
  input  logic [15:0] frame_height,
  output logic        done,
  output logic        status,
  output logic [7:0]  granted_index,
  output logic [31:0] buffer_addr,
  output logic [31:0] buffer_bytes,
  output logic [3:0]  buffers_made,
  output logic [2:0]  queue_slot
);

  localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam logic [CW-1:0] POOL_N = CW'(POOL_ENTRIES);
  localparam logic [FW-1:0] RING_N = FW'(RING_DEPTH);

  logic [31:0] entry_address [POOL_ENTRIES];
  logic [31:0] entry_bytes   [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] entry_busy;
  logic [CW-1:0] usable_count;
  logic [RW-1:0] ring_write_ptr, ring_read_ptr;
  logic [FW-1:0] ring_fill;

  logic [2:0]  op;
  logic [7:0]  idx;
  logic [31:0] size;
  logic [33:0] limit;
  logic [CW-1:0] lay_i, n;
  logic [35:0] lay_addr;  // base + i*size, running sum
  logic [35:0] top_end;   // base + n*size

  // ring memory
  logic          ring_we;
  logic [7:0]    ring_rdata;
  logic [RW-1:0] ring_raddr;

  fbpm_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_write_ptr),
    .wdata (idx),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  assign ring_raddr = ring_read_ptr;
  assign ring_we = cmd.simple && op == OP_ENQUEUE && ring_fill < RING_N;

  // lowest free usable entry
  logic          grant_ok;
  logic [PW-1:0] grant_i;
  always_comb begin
    grant_ok = 1'b0;
    grant_i  = '0;
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (CW'(i) < usable_count && !entry_busy[i] &&
          entry_address[i] != '0 && entry_bytes[i] != '0) begin
        grant_ok = 1'b1;
        grant_i  = PW'(i);
      end
    end
  end

  logic          idx_ok;
  logic [PW-1:0] idx_p;
  logic          deq_ok;
  logic [PW-1:0] deq_p;
  assign idx_ok = {24'd0, idx} < 32'(POOL_ENTRIES);
  assign idx_p  = PW'(idx);
  assign deq_ok = {24'd0, ring_rdata} < 32'(POOL_ENTRIES);
  assign deq_p  = PW'(ring_rdata);

  logic [CW-1:0] req_n;
  assign req_n = ({24'd0, requested_buffers} > 32'(POOL_ENTRIES)) ? POOL_N
                 : CW'(requested_buffers);

  assign stat.is_create   = op == OP_CREATE;
  assign stat.create_fail = region_start == '0 || region_length == '0 || req_n == '0;
  assign stat.lay_last    = lay_i == n - CW'(1);
  assign stat.trim_done   = n == '0 || top_end <= {2'b0, limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_busy     <= '0;
      usable_count   <= '0;
      ring_write_ptr <= '0;
      ring_read_ptr  <= '0;
      ring_fill      <= '0;
      done           <= 1'b0;
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        entry_address[i] <= '0;
        entry_bytes[i]   <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cmd.latch) begin
        op   <= opcode;
        idx  <= buffer_index;
        size <= frame_width * frame_height;
      end
      if (cmd.simple) begin
        done          <= 1'b1;
        status        <= 1'b1;
        granted_index <= '0;
        buffer_addr   <= '0;
        buffer_bytes  <= '0;
        buffers_made  <= '0;
        queue_slot    <= '0;
        case (op)
          OP_CREATE: begin
            done         <= stat.create_fail;
            buffers_made <= 4'(usable_count);
            if (region_start != '0 && region_length != '0) begin
              usable_count <= req_n;
              if (req_n == '0) buffers_made <= '0;
            end
          end
          OP_REQUEST: if (grant_ok) begin
            entry_busy[grant_i] <= 1'b1;
            granted_index <= 8'(grant_i);
            status <= 1'b0;
          end
          OP_ENQUEUE: if (ring_we) begin
            queue_slot     <= 3'(ring_write_ptr);
            ring_write_ptr <= (ring_write_ptr == RW'(RING_DEPTH - 1)) ? '0
                              : ring_write_ptr + RW'(1);
            ring_fill <= ring_fill + FW'(1);
            status    <= 1'b0;
          end
          OP_DEQUEUE: if (ring_fill != '0) begin
            granted_index <= ring_rdata;
            if (deq_ok) begin
              buffer_addr  <= entry_address[deq_p];
              buffer_bytes <= entry_bytes[deq_p];
            end
            ring_read_ptr <= (ring_read_ptr == RW'(RING_DEPTH - 1)) ? '0
                             : ring_read_ptr + RW'(1);
            ring_fill <= ring_fill - FW'(1);
            status    <= 1'b0;
          end
          OP_QUERY: if (idx_ok && entry_address[idx_p] != '0 &&
                        entry_bytes[idx_p] != '0) begin
            buffer_addr  <= entry_address[idx_p];
            buffer_bytes <= entry_bytes[idx_p];
            status       <= 1'b0;
          end
          OP_RELEASE: if (idx_ok) begin
            entry_busy[idx_p] <= 1'b0;
            status <= 1'b0;
          end
          default: status <= 1'b1;
        endcase
      end
      if (cmd.init) begin
        lay_addr <= {3'b0, ({1'b0, region_start} + ALIGN_ADD) & {1'b1, ALIGN_MASK}};
        limit    <= {2'b0, region_start} + {2'b0, region_length};
        lay_i    <= '0;
        n        <= req_n;
      end
      if (cmd.lay_step) begin
        entry_bytes[PW'(lay_i)]   <= size;
        entry_address[PW'(lay_i)] <= lay_addr[31:0];
        entry_busy[PW'(lay_i)]    <= 1'b0;
        lay_addr <= lay_addr + {4'b0, size};
        lay_i    <= lay_i + CW'(1);
        // end of top buffer = last address + size
        top_end  <= lay_addr + {4'b0, size};
      end
      if (cmd.trim_step && !stat.trim_done) begin
        n       <= n - CW'(1);
        top_end <= top_end - {4'b0, size};
      end
      if (cmd.finish) begin
        done         <= 1'b1;
        usable_count <= n;
        buffers_made <= 4'(n);
        status       <= n == '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    ring_fill <= RING_N) else $error("ring overfilled");
  assert property (@(posedge clk) disable iff (rst)
    usable_count <= POOL_N) else $error("usable count too large");
  assert property (@(posedge clk) disable iff (rst)
    ring_we |=> ring_fill != '0) else $error("push lost");

endmodule

[src/fbpm_ram.sv]
// ----------------------------------------------------------------------------
// fbpm_ram
// Generic single write, single read RAM with registered read.
// ----------------------------------------------------------------------------
module fbpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[src/frame_buffer_pool_manager_core.sv]
// sequence: request, enqueue, dequeue, query and release are latched in idle, run in
//   the size step and register their result; a create then walks layout, trim and done
// one command at a time: start is taken only when idle and no result is showing
// reset: synchronous; pool entries, busy flags, counts and ring pointers clear
// results are strobed for one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
// frame_buffer_pool_manager_core
// Frame buffer pool with a ring queue of filled frame indices.
// ----------------------------------------------------------------------------
module frame_buffer_pool_manager_core
  import fbpm_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int RING_DEPTH   = RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [7:0]  buffer_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic        status,
  output logic [7:0]  granted_index,
  output logic [31:0] buffer_addr,
  output logic [31:0] buffer_bytes,
  output logic [3:0]  buffers_made,
  output logic [2:0]  queue_slot
);

  logic [31:0] region_start, region_length;
  logic [7:0]  requested_buffers;
  logic [15:0] frame_width, frame_height;
  cmd_t  cmd;
  stat_t stat;
  logic  ctrl_busy;

  assign cfg_ready = 1'b1;
  assign busy = ctrl_busy || result_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start      <= '0;
      region_length     <= '0;
      requested_buffers <= '0;
      frame_width       <= '0;
      frame_height      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REGION_START:  region_start      <= cfg_data;
        REG_REGION_LENGTH: region_length     <= cfg_data;
        REG_REQUESTED:     requested_buffers <= cfg_data[7:0];
        REG_FRAME_WIDTH:   frame_width       <= cfg_data[15:0];
        REG_FRAME_HEIGHT:  frame_height      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  fbpm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start && !result_valid),
    .busy (ctrl_busy),
    .stat (stat),
    .cmd  (cmd)
  );

  fbpm_datapath #(.POOL_ENTRIES(POOL_ENTRIES), .RING_DEPTH(RING_DEPTH)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .opcode           (opcode),
    .buffer_index     (buffer_index),
    .region_start     (region_start),
    .region_length    (region_length),
    .requested_buffers(requested_buffers),
    .frame_width      (frame_width),
    .frame_height     (frame_height),
    .done             (result_valid),
    .status           (status),
    .granted_index    (granted_index),
    .buffer_addr      (buffer_addr),
    .buffer_bytes     (buffer_bytes),
    .buffers_made     (buffers_made),
    .queue_slot       (queue_slot)
  );

endmodule
